[rtl/core/rau_pkg.sv]
// Shared types and constants of the rational arithmetic unit.
`default_nettype none

package rau_pkg;

    localparam int NumW  = 32;
    localparam int DenW  = 31;
    localparam int WideW = 64;
    localparam int CntW  = $clog2(WideW);

    typedef enum logic [2:0] {
        OP_ADD   = 3'd0,
        OP_SUB   = 3'd1,
        OP_MUL   = 3'd2,
        OP_DIV   = 3'd3,
        OP_NEG   = 3'd4,
        OP_ABS   = 3'd5,
        OP_RECIP = 3'd6,
        OP_CMP   = 3'd7
    } t_opcode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_FORM,
        ST_GCD,
        ST_DIV_NUM,
        ST_DIV_DEN,
        ST_FINISH
    } t_state;

    // Product slots filled by the shared multiplier.
    localparam logic [1:0] MUL_X = 2'd0;
    localparam logic [1:0] MUL_Y = 2'd1;
    localparam logic [1:0] MUL_Z = 2'd2;

    // Divider operand selects.
    localparam logic DIV_SEL_NUM = 1'b0;
    localparam logic DIV_SEL_DEN = 1'b1;

    typedef struct packed {
        logic       load;
        logic       mul_en;
        logic [1:0] mul_step;
        logic       form;
        logic       gcd_step;
        logic       gcd_fin;
        logic       div_step;
        logic       div_last;
        logic       div_sel;
        logic       emit;
    } t_cmd;

    typedef struct packed {
        logic special;
        logic gcd_done;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

[rtl/core/rau_req_if.sv]
// Request channel of the rational arithmetic unit: opcode and two fractions.
`default_nettype none

interface rau_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         opcode;
    logic signed [31:0] a_num;
    logic [30:0]        a_den;
    logic signed [31:0] b_num;
    logic [30:0]        b_den;

    modport source (output valid, opcode, a_num, a_den, b_num, b_den, input ready);
    modport sink   (input valid, opcode, a_num, a_den, b_num, b_den, output ready);
endinterface

`default_nettype wire

[rtl/core/rau_res_if.sv]
// Result channel of the rational arithmetic unit: reduced fraction and flags.
`default_nettype none

interface rau_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] res_num;
    logic [30:0]        res_den;
    logic               less;
    logic               equal;
    logic               greater;
    logic               div_zero;
    logic               overflow;

    modport source (output valid, res_num, res_den, less, equal, greater, div_zero,
                    overflow, input ready);
    modport sink   (input valid, res_num, res_den, less, equal, greater, div_zero,
                    overflow, output ready);
endinterface

`default_nettype wire

[rtl/core/rau_ctrl.sv]
// Sequencer of the rational arithmetic unit.
`default_nettype none

module rau_ctrl
    import rau_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state            r_state, n_state;
    logic [CntW-1:0]   r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_MUL;
                    n_cnt   = '0;
                end
            end
            ST_MUL: begin
                if (r_cnt[1:0] == MUL_Z) begin
                    n_state = ST_FORM;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_FORM: begin
                n_state = i_status.special ? ST_FINISH : ST_GCD;
            end
            ST_GCD: begin
                if (i_status.gcd_done) begin
                    n_state = ST_DIV_NUM;
                    n_cnt   = '0;
                end
            end
            ST_DIV_NUM: begin
                n_cnt = r_cnt + 1'b1;
                if (&r_cnt) begin
                    n_state = ST_DIV_DEN;
                end
            end
            ST_DIV_DEN: begin
                n_cnt = r_cnt + 1'b1;
                if (&r_cnt) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_MUL: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_step = r_cnt[1:0];
            end
            ST_FORM: begin
                o_cmd.form = 1'b1;
            end
            ST_GCD: begin
                o_cmd.gcd_fin  = i_status.gcd_done;
                o_cmd.gcd_step = !i_status.gcd_done;
            end
            ST_DIV_NUM: begin
                o_cmd.div_step = 1'b1;
                o_cmd.div_last = &r_cnt;
                o_cmd.div_sel  = DIV_SEL_NUM;
            end
            ST_DIV_DEN: begin
                o_cmd.div_step = 1'b1;
                o_cmd.div_last = &r_cnt;
                o_cmd.div_sel  = DIV_SEL_DEN;
            end
            ST_FINISH: begin
                o_cmd.emit = i_status.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/core/rau_dpath.sv]
// Datapath of the rational arithmetic unit: multiplier, GCD, divider, result register.
`default_nettype none

module rau_dpath
    import rau_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
)(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    input  logic [2:0]             i_opcode,
    input  logic signed [NumW-1:0] i_a_num,
    input  logic [DenW-1:0]        i_a_den,
    input  logic signed [NumW-1:0] i_b_num,
    input  logic [DenW-1:0]        i_b_den,
    input  logic                   i_out_ready,
    output t_status                o_status,
    output logic                   o_out_valid,
    output logic signed [NumW-1:0] o_res_num,
    output logic [DenW-1:0]        o_res_den,
    output logic                   o_less,
    output logic                   o_equal,
    output logic                   o_greater,
    output logic                   o_div_zero,
    output logic                   o_overflow
);

    localparam logic [WideW-1:0] Lim = (WideW'(1) << (VALUE_WIDTH - 1)) - WideW'(1);

    // Operand registers.
    t_opcode                r_op;
    logic signed [NumW-1:0] r_an, r_bn;
    logic [DenW-1:0]        r_ad, r_bd;

    // Products and the working values of the reduction.
    logic signed [WideW-1:0] r_x, r_y, r_z;
    logic [WideW-1:0]        r_nm, r_dn, r_u, r_v, r_g, r_rem, r_quo;
    logic [CntW-1:0]         r_k;
    logic                    r_neg, r_special, r_dz, r_less, r_equal, r_greater;

    // Result register.
    logic                   r_out_valid;
    logic signed [NumW-1:0] r_res_num;
    logic [DenW-1:0]        r_res_den;
    logic                   r_o_less, r_o_equal, r_o_greater, r_o_dz, r_o_ovf;

    // Shared signed multiplier.
    logic signed [NumW:0]     mul_a, mul_b;
    logic signed [2*NumW+1:0] mul_p;

    always_comb begin
        case (i_cmd.mul_step)
            MUL_X: begin
                mul_a = {r_an[NumW-1], r_an};
                mul_b = (r_op == OP_MUL) ? {r_bn[NumW-1], r_bn} : {2'b00, r_bd};
            end
            MUL_Y: begin
                mul_a = {r_bn[NumW-1], r_bn};
                mul_b = {2'b00, r_ad};
            end
            default: begin
                mul_a = {2'b00, r_ad};
                mul_b = (r_op == OP_DIV) ? {r_bn[NumW-1], r_bn} : {2'b00, r_bd};
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // Sign, magnitudes and special cases of the unreduced result.
    logic                    f_binary, f_dz, f_cmp, f_neg, f_special;
    logic signed [WideW-1:0] f_s, an_ext;
    logic [WideW-1:0]        f_nm, f_dn, an_mag;

    always_comb begin
        an_ext   = {{(WideW-NumW){r_an[NumW-1]}}, r_an};
        an_mag   = r_an[NumW-1] ? WideW'(-an_ext) : WideW'(an_ext);
        f_binary = (r_op == OP_ADD) || (r_op == OP_SUB) || (r_op == OP_MUL) ||
                   (r_op == OP_DIV) || (r_op == OP_CMP);
        f_dz     = (r_ad == '0) || (f_binary && (r_bd == '0)) ||
                   ((r_op == OP_DIV) && (r_bn == '0)) ||
                   ((r_op == OP_RECIP) && (r_an == '0));
        case (r_op)
            OP_ADD:  f_s = r_x + r_y;
            OP_SUB:  f_s = r_x - r_y;
            default: f_s = r_x;
        endcase
        f_nm  = f_s[WideW-1] ? WideW'(-f_s) : WideW'(f_s);
        f_dn  = r_z[WideW-1] ? WideW'(-r_z) : WideW'(r_z);
        f_neg = f_s[WideW-1];
        case (r_op)
            OP_DIV: begin
                f_neg = r_x[WideW-1] ^ r_z[WideW-1];
            end
            OP_NEG: begin
                f_nm  = an_mag;
                f_dn  = {{(WideW-DenW){1'b0}}, r_ad};
                f_neg = !r_an[NumW-1] && (r_an != '0);
            end
            OP_ABS: begin
                f_nm  = an_mag;
                f_dn  = {{(WideW-DenW){1'b0}}, r_ad};
                f_neg = 1'b0;
            end
            OP_RECIP: begin
                f_nm  = {{(WideW-DenW){1'b0}}, r_ad};
                f_dn  = an_mag;
                f_neg = r_an[NumW-1];
            end
            default: begin
                f_neg = f_neg;
            end
        endcase
        f_cmp     = (r_op == OP_CMP);
        f_special = f_dz || f_cmp || (f_nm == '0);
    end

    // Binary GCD step: strip common factors of two, then subtract the odd values.
    logic                  g_done;
    logic [WideW-1:0]      g_u, g_v;
    logic [CntW-1:0]       g_k;

    always_comb begin
        g_done = (r_u == '0) || (r_v == '0);
        g_u    = r_u;
        g_v    = r_v;
        g_k    = r_k;
        if (!r_u[0] && !r_v[0]) begin
            g_u = r_u >> 1;
            g_v = r_v >> 1;
            g_k = r_k + 1'b1;
        end else if (!r_u[0]) begin
            g_u = r_u >> 1;
        end else if (!r_v[0]) begin
            g_v = r_v >> 1;
        end else if (r_u >= r_v) begin
            g_u = (r_u - r_v) >> 1;
        end else begin
            g_v = (r_v - r_u) >> 1;
        end
    end

    // Restoring divider, one quotient bit per cycle.
    logic [WideW:0]   d_t, d_diff;
    logic             d_ge;
    logic [WideW-1:0] d_rem, d_quo;

    always_comb begin
        d_t    = {r_rem, r_quo[WideW-1]};
        d_diff = d_t - {1'b0, r_g};
        d_ge   = (d_t >= {1'b0, r_g});
        d_rem  = d_ge ? d_diff[WideW-1:0] : d_t[WideW-1:0];
        d_quo  = {r_quo[WideW-2:0], d_ge};
    end

    // Range test and final sign of the reduced result.
    logic             e_ovf;
    logic [WideW-1:0] e_num;

    always_comb begin
        e_ovf = !r_special && ((r_nm > Lim) || (r_dn > Lim));
        e_num = r_neg ? (WideW'(0) - r_nm) : r_nm;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= t_opcode'(i_opcode);
            r_an <= i_a_num;
            r_ad <= i_a_den;
            r_bn <= i_b_num;
            r_bd <= i_b_den;
        end
        if (i_cmd.mul_en) begin
            case (i_cmd.mul_step)
                MUL_X:   r_x <= mul_p[WideW-1:0];
                MUL_Y:   r_y <= mul_p[WideW-1:0];
                default: r_z <= mul_p[WideW-1:0];
            endcase
        end
        if (i_cmd.form) begin
            r_nm      <= f_nm;
            r_dn      <= f_dn;
            r_u       <= f_nm;
            r_v       <= f_dn;
            r_k       <= '0;
            r_neg     <= f_neg;
            r_special <= f_special;
            r_dz      <= f_dz;
            r_less    <= f_cmp && !f_dz && (r_x < r_y);
            r_equal   <= f_cmp && !f_dz && (r_x == r_y);
            r_greater <= f_cmp && !f_dz && (r_x > r_y);
        end
        if (i_cmd.gcd_step) begin
            r_u <= g_u;
            r_v <= g_v;
            r_k <= g_k;
        end
        if (i_cmd.gcd_fin) begin
            r_g   <= (r_u | r_v) << r_k;
            r_rem <= '0;
            r_quo <= r_nm;
        end
        if (i_cmd.div_step) begin
            if (i_cmd.div_last && (i_cmd.div_sel == DIV_SEL_NUM)) begin
                // Numerator done: keep its quotient and start on the denominator.
                r_nm  <= d_quo;
                r_quo <= r_dn;
                r_rem <= '0;
            end else begin
                r_rem <= d_rem;
                r_quo <= d_quo;
                if (i_cmd.div_last) begin
                    r_dn <= d_quo;
                end
            end
        end
        if (i_cmd.emit) begin
            r_res_num   <= (r_special || e_ovf) ? '0 : e_num[NumW-1:0];
            r_res_den   <= (r_special || e_ovf) ? DenW'(1) : r_dn[DenW-1:0];
            r_o_less    <= r_less;
            r_o_equal   <= r_equal;
            r_o_greater <= r_greater;
            r_o_dz      <= r_dz;
            r_o_ovf     <= e_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.special  = f_special;
    assign o_status.gcd_done = g_done;
    assign o_status.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_res_num   = r_res_num;
    assign o_res_den   = r_res_den;
    assign o_less      = r_o_less;
    assign o_equal     = r_o_equal;
    assign o_greater   = r_o_greater;
    assign o_div_zero  = r_o_dz;
    assign o_overflow  = r_o_ovf;

endmodule

`default_nettype wire

[rtl/core/rational_arithmetic_unit.sv]
// Top level of the rational arithmetic unit: sequencer, datapath and channel hookup.
`default_nettype none

// The unit takes one request at a time (opcode plus two signed fractions a and b)
// and returns one result: a fraction reduced to lowest terms with the sign on the
// numerator, a positive denominator, and zero given as 0/1. Add, subtract and
// compare cross-multiply through one shared 33x33 signed multiplier, the
// unreduced fraction is then formed, a binary GCD takes one step per cycle, and a
// restoring divider then reduces numerator and denominator at one quotient bit per
// cycle. Compare, division by zero and zero results skip the GCD and the divider.
// The request side is ready only while the sequencer is idle. Results sit in an
// output register, so a new request is taken while the previous result still
// waits on the result channel. Division by zero (or a zero denominator on a used
// operand) sets div_zero, and a reduced numerator or denominator whose magnitude
// exceeds 2^(VALUE_WIDTH-1)-1 sets overflow; both force the result to 0/1.
// Compare without a zero denominator sets exactly one of less, equal and greater
// and returns 0/1.

module rational_arithmetic_unit
    import rau_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
)(
    input  logic      i_clk,
    input  logic      i_rst_n,
    rau_req_if.sink   i_req,
    rau_res_if.source o_res
);

    t_cmd    cmd;
    t_status status;

    rau_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    rau_dpath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_opcode    (i_req.opcode),
        .i_a_num     (i_req.a_num),
        .i_a_den     (i_req.a_den),
        .i_b_num     (i_req.b_num),
        .i_b_den     (i_req.b_den),
        .i_out_ready (o_res.ready),
        .o_status    (status),
        .o_out_valid (o_res.valid),
        .o_res_num   (o_res.res_num),
        .o_res_den   (o_res.res_den),
        .o_less      (o_res.less),
        .o_equal     (o_res.equal),
        .o_greater   (o_res.greater),
        .o_div_zero  (o_res.div_zero),
        .o_overflow  (o_res.overflow)
    );

`ifndef NO_ASSERTIONS
    // A delivered denominator is never zero.
    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.res_den != '0))
        else $error("result denominator is zero");

    // At most one compare outcome is reported.
    a_cmp_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> $onehot0({o_res.less, o_res.equal, o_res.greater}))
        else $error("more than one compare flag set");

    // An error flag always comes with the forced 0/1 result.
    a_err_forced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.div_zero || o_res.overflow)) |->
        ((o_res.res_num == '0) && (o_res.res_den == DenW'(1))))
        else $error("error flag without 0/1 result");

    // Division by zero and overflow never occur together.
    a_err_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> !(o_res.div_zero && o_res.overflow))
        else $error("div_zero and overflow both set");
`endif

endmodule

`default_nettype wire
